>>> hdl/bmg_pkg.sv
package bmg_pkg;

  localparam int NumFaces = 6;
  localparam int CornersPerFace = 4;
  localparam int VertsPerBox = NumFaces * CornersPerFace;
  localparam logic signed [15:0] Q14One = 16'sd16384;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAT   = 6'b000010,
    S_PROD  = 6'b000100,
    S_SUM   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_TRI   = 6'b100000
  } state_t;

  typedef struct packed {
    logic       load;
    logic [3:0] mat_step;
    logic       mat_en;
    logic       prod_en;
    logic       sum_en;
    logic       out_vertex;
    logic       out_tri;
    logic [2:0] face;
    logic [1:0] corner;
    logic       tri_k;
    logic       box_done;
  } cmd_t;

  function automatic logic [2:0] corner_sign(input logic [2:0] f, input logic [1:0] k);
    logic [2:0] s;
    s = 3'b000;
    case ({f, k})
      {3'd0, 2'd0}: s = 3'b110; {3'd0, 2'd1}: s = 3'b100;
      {3'd0, 2'd2}: s = 3'b101; {3'd0, 2'd3}: s = 3'b111;
      {3'd1, 2'd0}: s = 3'b011; {3'd1, 2'd1}: s = 3'b001;
      {3'd1, 2'd2}: s = 3'b000; {3'd1, 2'd3}: s = 3'b010;
      {3'd2, 2'd0}: s = 3'b010; {3'd2, 2'd1}: s = 3'b011;
      {3'd2, 2'd2}: s = 3'b111; {3'd2, 2'd3}: s = 3'b110;
      {3'd3, 2'd0}: s = 3'b001; {3'd3, 2'd1}: s = 3'b000;
      {3'd3, 2'd2}: s = 3'b100; {3'd3, 2'd3}: s = 3'b101;
      {3'd4, 2'd0}: s = 3'b111; {3'd4, 2'd1}: s = 3'b101;
      {3'd4, 2'd2}: s = 3'b001; {3'd4, 2'd3}: s = 3'b011;
      {3'd5, 2'd0}: s = 3'b010; {3'd5, 2'd1}: s = 3'b000;
      {3'd5, 2'd2}: s = 3'b100; {3'd5, 2'd3}: s = 3'b110;
      default: s = 3'b000;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/box_mesh_generator.sv
// A box is taken only in S_IDLE and first builds its rotation matrix in S_MAT;
// each vertex then takes a product step, a sum step that registers the output
// and an output step that holds until out_ready; the product step uses the shared
// 3x3 multiplier array. The matrix is built one entry a cycle by one multiplier pair.
// Reset: synchronous rst clears the controller and the vertex counter.
module box_mesh_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic        [30:0] half_x,
  input  logic        [30:0] half_y,
  input  logic        [30:0] half_z,
  input  logic signed [15:0] rot_w,
  input  logic signed [15:0] rot_x,
  input  logic signed [15:0] rot_y,
  input  logic signed [15:0] rot_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic        [31:0] corner_a,
  output logic        [31:0] corner_b,
  output logic        [31:0] corner_c,
  output logic               last
);

  bmg_pkg::cmd_t cmd;

  bmg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  bmg_path u_path (
    .clk(clk), .rst(rst), .cmd(cmd),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .half_x(half_x), .half_y(half_y), .half_z(half_z),
    .rot_w(rot_w), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .kind(kind), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c), .last(last)
  );

endmodule

>>> hdl/bmg_ctrl.sv
module bmg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bmg_pkg::cmd_t cmd
);

  bmg_pkg::state_t state, state_next;
  logic [3:0] step, step_next;
  logic [2:0] face, face_next;
  logic [1:0] corner, corner_next;
  logic       tri_k, tri_k_next;
  logic       ov, ov_next;

  assign in_ready = (state == bmg_pkg::S_IDLE);
  assign out_valid = ov;

  always_comb begin
    state_next = state;
    step_next = step;
    face_next = face;
    corner_next = corner;
    tri_k_next = tri_k;
    ov_next = ov;
    cmd = '0;
    cmd.mat_step = step;
    cmd.face = face;
    cmd.corner = corner;
    cmd.tri_k = tri_k;
    case (state)
      bmg_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          step_next = '0;
          face_next = '0;
          corner_next = '0;
          tri_k_next = 1'b0;
          state_next = bmg_pkg::S_MAT;
        end
      end
      bmg_pkg::S_MAT: begin
        cmd.mat_en = 1'b1;
        step_next = step + 4'd1;
        if (step == 4'd9) begin
          state_next = bmg_pkg::S_PROD;
        end
      end
      bmg_pkg::S_PROD: begin
        cmd.prod_en = 1'b1;
        state_next = bmg_pkg::S_SUM;
      end
      bmg_pkg::S_SUM: begin
        cmd.sum_en = 1'b1;
        cmd.out_vertex = 1'b1;
        ov_next = 1'b1;
        state_next = bmg_pkg::S_EMIT;
      end
      bmg_pkg::S_EMIT: begin
        if (out_ready) begin
          ov_next = 1'b0;
          if (corner == 2'd3) begin
            corner_next = '0;
            tri_k_next = 1'b0;
            cmd.tri_k = 1'b0;
            cmd.out_tri = 1'b1;
            ov_next = 1'b1;
            state_next = bmg_pkg::S_TRI;
          end else begin
            corner_next = corner + 2'd1;
            state_next = bmg_pkg::S_PROD;
          end
        end
      end
      bmg_pkg::S_TRI: begin
        if (out_ready) begin
          if (!tri_k) begin
            tri_k_next = 1'b1;
            cmd.tri_k = 1'b1;
            cmd.out_tri = 1'b1;
          end else begin
            ov_next = 1'b0;
            if (face == 3'd5) begin
              cmd.box_done = 1'b1;
              state_next = bmg_pkg::S_IDLE;
            end else begin
              face_next = face + 3'd1;
              state_next = bmg_pkg::S_PROD;
            end
          end
        end
      end
      default: state_next = bmg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmg_pkg::S_IDLE;
      ov <= 1'b0;
      step <= '0;
      face <= '0;
      corner <= '0;
      tri_k <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
      step <= step_next;
      face <= face_next;
      corner <= corner_next;
      tri_k <= tri_k_next;
    end
  end

endmodule

>>> hdl/bmg_path.sv
module bmg_path (
  input  logic               clk,
  input  logic               rst,
  input  bmg_pkg::cmd_t      cmd,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic        [30:0] half_x,
  input  logic        [30:0] half_y,
  input  logic        [30:0] half_z,
  input  logic signed [15:0] rot_w,
  input  logic signed [15:0] rot_x,
  input  logic signed [15:0] rot_y,
  input  logic signed [15:0] rot_z,
  output logic               kind,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic        [31:0] corner_a,
  output logic        [31:0] corner_b,
  output logic        [31:0] corner_c,
  output logic               last
);

  logic signed [31:0] c [3];
  logic        [30:0] h [3];
  logic signed [15:0] q [4];
  logic signed [33:0] m [9];
  logic signed [48:0] prod [9];
  logic [31:0] vertex_count;

  logic signed [15:0] qa, qb, qc, qd;
  logic signed [33:0] pa, pb, mval;
  logic [3:0] mstep;

  assign mstep = cmd.mat_step;

  // select quaternion products per matrix entry, row-major
  always_comb begin
    qa = q[0]; qb = q[0]; qc = q[0]; qd = q[0];
    case (mstep)
      4'd0: begin qa = q[2]; qb = q[2]; qc = q[3]; qd = q[3]; end
      4'd1: begin qa = q[1]; qb = q[2]; qc = q[0]; qd = q[3]; end
      4'd2: begin qa = q[1]; qb = q[3]; qc = q[0]; qd = q[2]; end
      4'd3: begin qa = q[1]; qb = q[2]; qc = q[0]; qd = q[3]; end
      4'd4: begin qa = q[1]; qb = q[1]; qc = q[3]; qd = q[3]; end
      4'd5: begin qa = q[2]; qb = q[3]; qc = q[0]; qd = q[1]; end
      4'd6: begin qa = q[1]; qb = q[3]; qc = q[0]; qd = q[2]; end
      4'd7: begin qa = q[2]; qb = q[3]; qc = q[0]; qd = q[1]; end
      4'd8: begin qa = q[1]; qb = q[1]; qc = q[2]; qd = q[2]; end
      default: ;
    endcase
    pa = 34'(qa * qb);
    pb = 34'(qc * qd);
    case (mstep)
      4'd0, 4'd4, 4'd8: mval = (34'sd1 <<< 28) - ((pa + pb) <<< 1);
      4'd1, 4'd5, 4'd6: mval = (pa - pb) <<< 1;
      default: mval = (pa + pb) <<< 1;
    endcase
  end

  logic signed [33:0] mround;
  assign mround = (mval + 34'sd8192) >>> 14;

  logic [2:0] sgn;
  logic [1:0] axis;
  logic neg;
  logic signed [31:0] hs [3];
  logic signed [51:0] acc [3];
  logic signed [37:0] rr [3];
  logic signed [38:0] tot [3];
  logic signed [31:0] pos [3];
  logic signed [33:0] nv [3];
  logic signed [15:0] nsat [3];
  logic [31:0] base;

  always_comb begin
    sgn = bmg_pkg::corner_sign(cmd.face, cmd.corner);
    axis = 2'(cmd.face[2:1]);
    neg = cmd.face[0];
    for (int j = 0; j < 3; j++) begin
      hs[j] = sgn[2-j] ? $signed({1'b0, h[j]}) : -$signed({1'b0, h[j]});
    end
    for (int i = 0; i < 3; i++) begin
      acc[i] = 52'(prod[3*i]) + 52'(prod[3*i+1]) + 52'(prod[3*i+2]);
      rr[i] = 38'((acc[i] + 52'sd8192) >>> 14);
      tot[i] = 39'(c[i]) + 39'(rr[i]);
      if (tot[i] > 39'sd2147483647) pos[i] = 32'sh7fffffff;
      else if (tot[i] < -39'sd2147483648) pos[i] = 32'sh80000000;
      else pos[i] = tot[i][31:0];
      nv[i] = neg ? -m[3*i+axis] : m[3*i+axis];
      if (nv[i] > 34'sd16384) nsat[i] = bmg_pkg::Q14One;
      else if (nv[i] < -34'sd16384) nsat[i] = -bmg_pkg::Q14One;
      else nsat[i] = nv[i][15:0];
    end
    base = vertex_count + 32'({cmd.face, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c[0] <= center_x; c[1] <= center_y; c[2] <= center_z;
      h[0] <= half_x; h[1] <= half_y; h[2] <= half_z;
      q[0] <= rot_w; q[1] <= rot_x; q[2] <= rot_y; q[3] <= rot_z;
    end
    if (cmd.mat_en && mstep < 4'd9) m[mstep] <= mround;
    if (cmd.prod_en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          prod[3*i+j] <= 49'(m[3*i+j]) * 49'(hs[j]);
    end
    if (cmd.out_vertex) begin
      kind <= 1'b0; last <= 1'b0;
      pos_x <= pos[0]; pos_y <= pos[1]; pos_z <= pos[2];
      norm_x <= nsat[0]; norm_y <= nsat[1]; norm_z <= nsat[2];
      corner_a <= '0; corner_b <= '0; corner_c <= '0;
    end
    if (cmd.out_tri) begin
      kind <= 1'b1;
      pos_x <= '0; pos_y <= '0; pos_z <= '0;
      norm_x <= '0; norm_y <= '0; norm_z <= '0;
      corner_a <= base;
      corner_b <= base + (cmd.tri_k ? 32'd2 : 32'd1);
      corner_c <= base + (cmd.tri_k ? 32'd3 : 32'd2);
      last <= cmd.tri_k && (cmd.face == 3'd5);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cmd.box_done) begin
      vertex_count <= vertex_count + 32'(bmg_pkg::VertsPerBox);
    end
  end

endmodule

>>> hdl/bmg_checker.sv
module bmg_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic kind,
  input logic last,
  input logic [31:0] corner_a,
  input logic [31:0] corner_b,
  input logic [31:0] corner_c
);

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while results pending");

  a_last_is_tri: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> kind) else $error("last on a vertex item");

  a_tri_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind) |-> (corner_c == corner_b + 32'd1))
    else $error("triangle corners out of order");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(corner_a)))
    else $error("stalled item changed");

endmodule

bind box_mesh_generator bmg_checker u_bmg_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .last(last),
  .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c)
);

>>> tb/tb_box_mesh_generator.sv
`timescale 1ns / 1ps

module tb_box_mesh_generator;

  typedef struct {
    logic signed [31:0] cx, cy, cz;
    logic [30:0] hx, hy, hz;
    logic signed [15:0] qw, qx, qy, qz;
  } box_t;

  typedef struct {
    logic kind;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [31:0] ca, cb, cc;
    logic last;
  } mesh_item_t;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRI = 1'b1;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] center_x, center_y, center_z;
  logic [30:0] half_x, half_y, half_z;
  logic signed [15:0] rot_w, rot_x, rot_y, rot_z;
  logic kind, last;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic [31:0] corner_a, corner_b, corner_c;

  box_t pending_boxes[$];
  mesh_item_t expected_mesh[$];
  logic [31:0] vert_base;
  int send_idle_pct, recv_idle_pct;
  int mismatches, items_checked, boxes_sent;
  bit hold_send;

  box_mesh_generator dut (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic void queue_box(box_t b);
    pending_boxes.insert(pending_boxes.size(), b);
  endfunction

  function automatic void expect_item(mesh_item_t it);
    expected_mesh.insert(expected_mesh.size(), it);
  endfunction

  function automatic longint round14(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int csign(int f, int k, int j);
    logic [2:0] s;
    s = bmg_pkg::corner_sign(f[2:0], k[1:0]);
    return s[2 - j] ? 1 : -1;
  endfunction

  task automatic predict_box(box_t b);
    longint m[3][3], c[3], h[3], acc;
    longint w, x, y, z, one;
    mesh_item_t it;
    logic [31:0] base;
    int ax, sg;
    w = b.qw; x = b.qx; y = b.qy; z = b.qz;
    one = 64'sd1 << 28;
    c[0] = b.cx; c[1] = b.cy; c[2] = b.cz;
    h[0] = b.hx; h[1] = b.hy; h[2] = b.hz;
    m[0][0] = one - 2 * (y * y + z * z);
    m[0][1] = 2 * (x * y - w * z);
    m[0][2] = 2 * (x * z + w * y);
    m[1][0] = 2 * (x * y + w * z);
    m[1][1] = one - 2 * (x * x + z * z);
    m[1][2] = 2 * (y * z - w * x);
    m[2][0] = 2 * (x * z - w * y);
    m[2][1] = 2 * (y * z + w * x);
    m[2][2] = one - 2 * (x * x + y * y);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = round14(m[i][j]);
    for (int f = 0; f < bmg_pkg::NumFaces; f++) begin
      base = vert_base + 32'(bmg_pkg::CornersPerFace * f);
      ax = f / 2;
      sg = (f % 2) ? -1 : 1;
      for (int k = 0; k < bmg_pkg::CornersPerFace; k++) begin
        longint p[3];
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += m[i][j] * (csign(f, k, j) * h[j]);
          p[i] = clamp(c[i] + round14(acc), -64'sd2147483648, 64'sd2147483647);
        end
        it.kind = KIND_VERTEX;
        it.px = p[0][31:0]; it.py = p[1][31:0]; it.pz = p[2][31:0];
        it.nx = 16'(clamp(sg * m[0][ax], -16384, 16384));
        it.ny = 16'(clamp(sg * m[1][ax], -16384, 16384));
        it.nz = 16'(clamp(sg * m[2][ax], -16384, 16384));
        it.ca = '0; it.cb = '0; it.cc = '0; it.last = 1'b0;
        expect_item(it);
      end
      for (int k = 0; k < 2; k++) begin
        it.kind = KIND_TRI;
        it.px = '0; it.py = '0; it.pz = '0;
        it.nx = '0; it.ny = '0; it.nz = '0;
        it.ca = base;
        it.cb = base + 32'd1 + 32'(k);
        it.cc = base + 32'd2 + 32'(k);
        it.last = (f == bmg_pkg::NumFaces - 1) && (k == 1);
        expect_item(it);
      end
    end
    vert_base += 32'(bmg_pkg::VertsPerBox);
  endtask

  function automatic box_t random_box(int mode);
    box_t b;
    int r;
    b.cx = $urandom; b.cy = $urandom; b.cz = $urandom;
    b.hx = 31'($urandom); b.hy = 31'($urandom); b.hz = 31'($urandom);
    if (mode != 0) begin
      // keep most boxes away from saturation
      b.cx = $signed(b.cx) >>> 8; b.cy = $signed(b.cy) >>> 8;
      b.cz = $signed(b.cz) >>> 8;
      b.hx = b.hx >> 10; b.hy = b.hy >> 10; b.hz = b.hz >> 10;
    end
    r = $urandom_range(0, 3);
    if (r == 0) begin
      b.qw = 16'($urandom_range(0, 32768) - 16384);
      b.qx = 16'($urandom_range(0, 32768) - 16384);
      b.qy = 16'($urandom_range(0, 32768) - 16384);
      b.qz = 16'($urandom_range(0, 32768) - 16384);
    end else begin
      real a, bb, cc, dd, n;
      a = $urandom_range(0, 2000) - 1000.0; bb = $urandom_range(0, 2000) - 1000.0;
      cc = $urandom_range(0, 2000) - 1000.0; dd = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(a * a + bb * bb + cc * cc + dd * dd);
      if (n < 1.0) begin a = 1.0; n = 1.0; end
      b.qw = 16'($rtoi(a / n * 16384.0)); b.qx = 16'($rtoi(bb / n * 16384.0));
      b.qy = 16'($rtoi(cc / n * 16384.0)); b.qz = 16'($rtoi(dd / n * 16384.0));
    end
    return b;
  endfunction

  function automatic box_t make_box(int cx, int hx, int qw, int qx, int qy, int qz);
    box_t b;
    b.cx = cx; b.cy = -cx; b.cz = cx;
    b.hx = 31'(hx); b.hy = 31'(hx); b.hz = 31'(hx);
    b.qw = 16'(qw); b.qx = 16'(qx); b.qy = 16'(qy); b.qz = 16'(qz);
    return b;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!in_valid || in_ready) begin
        if (in_valid && in_ready) boxes_sent++;
        if (!hold_send && pending_boxes.size() > 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          box_t b;
          b = pending_boxes.pop_front();
          predict_box(b);
          center_x <= b.cx; center_y <= b.cy; center_z <= b.cz;
          half_x <= b.hx; half_y <= b.hy; half_z <= b.hz;
          rot_w <= b.qw; rot_x <= b.qx; rot_y <= b.qy; rot_z <= b.qz;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      mesh_item_t e;
      items_checked++;
      if (expected_mesh.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item kind=%0d", kind);
      end else begin
        e = expected_mesh.pop_front();
        if (kind !== e.kind || pos_x !== e.px || pos_y !== e.py || pos_z !== e.pz ||
            norm_x !== e.nx || norm_y !== e.ny || norm_z !== e.nz ||
            corner_a !== e.ca || corner_b !== e.cb || corner_c !== e.cc ||
            last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp k%0d p(%0d %0d %0d) n(%0d %0d %0d) c(%0d %0d %0d) l%0d",
                     e.kind, e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.ca, e.cb, e.cc,
                     e.last, "\n          got k%0d p(%0d %0d %0d) n(%0d %0d %0d) c(%0d %0d %0d) l%0d",
                     kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                     corner_a, corner_b, corner_c, last);
        end
      end
    end
  end

  task automatic drain();
    while (pending_boxes.size() > 0 || in_valid || expected_mesh.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; out_ready = 1'b0;
    center_x = '0; center_y = '0; center_z = '0;
    half_x = '0; half_y = '0; half_z = '0;
    rot_w = '0; rot_x = '0; rot_y = '0; rot_z = '0;
    vert_base = '0;
    mismatches = 0; items_checked = 0; boxes_sent = 0;
    hold_send = 1'b0;
    send_idle_pct = 37; recv_idle_pct = 63;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    queue_box(make_box(0, 0, 16384, 0, 0, 0));
    queue_box(make_box(0, 65536, 16384, 0, 0, 0));
    queue_box(make_box(32'h7fffffff, 32'h7fffffff, 16384, 0, 0, 0));
    queue_box(make_box(32'h80000000, 32'h7fffffff, 16384, 0, 0, 0));
    queue_box(make_box(32'h7fffffff, 32'h7fffffff, -16384, 0, 0, 0));
    queue_box(make_box(1000, 131072, 0, 16384, 0, 0));
    queue_box(make_box(-1000, 131072, 0, 0, 16384, 0));
    queue_box(make_box(5, 131072, 0, 0, 0, 16384));
    queue_box(make_box(0, 65536, 11585, 11585, 0, 0));
    queue_box(make_box(0, 65536, 16384, 16384, 16384, 16384));
    queue_box(make_box(0, 65536, -16384, -16384, -16384, -16384));
    queue_box(make_box(0, 65536, 0, 0, 0, 0));
    queue_box(make_box(-7, 3, 8192, -8192, 8192, -8192));
    queue_box(make_box(32'h40000000, 32'h7fffffff, 11585, 0, 0, 11585));
    queue_box(make_box(32'h80000000, 1, 16384, -16384, 16384, -16384));
    drain();

    // pause the sender until the mesh drains
    for (int i = 0; i < 100; i++) queue_box(random_box(i % 5));
    while (pending_boxes.size() > 50) @(posedge clk);
    hold_send = 1'b1;
    while (in_valid || expected_mesh.size() > 0) @(posedge clk);
    hold_send = 1'b0;
    drain();

    send_idle_pct = 63; recv_idle_pct = 37;
    for (int i = 0; i < 100; i++) queue_box(random_box(i % 5));
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 100; i++) queue_box(random_box(i % 5));
    drain();
    repeat (100) @(posedge clk);

    $display("Sent %0d boxes (saturating, unnormalized and random rotations),",
             boxes_sent);
    $display("checked %0d items.", items_checked);
    if (mismatches == 0 && expected_mesh.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout with %0d items pending", expected_mesh.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
